// ===== design/pfht_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pfht_pkg
// Shared types and constants for the polygon fan hit test unit.
// -----------------------------------------------------------------------------
`default_nettype none

package pfht_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W      = 16;
	localparam int AREA_W       = 40;

	localparam logic [1:0] KIND_CLEAR     = 2'd0;
	localparam logic [1:0] KIND_APPEND    = 2'd1;
	localparam logic [1:0] KIND_QUERY     = 2'd2;
	localparam logic [1:0] KIND_TRANSLATE = 2'd3;

	typedef struct packed {
		logic [1:0]                 kind;
		logic signed [COORD_W-1:0]  coord_x;
		logic signed [COORD_W-1:0]  coord_y;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic             status;
		logic [CNT_W-1:0] vertex_count;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	// one fan triangle (v0, va, vb) tested against query point vp
	typedef struct packed {
		logic   valid;
		point_t v0;
		point_t va;
		point_t vb;
		point_t vp;
	} tri_req_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} tri_stat_t;

endpackage

`default_nettype wire

// ===== design/polygon_fan_hit_test_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// polygon_fan_hit_test_unit
// Vertex store with clear, append, translate and fan-triangle hit queries.
//
//   channel | signals                    | direction | payload
//   --------+----------------------------+-----------+---------------------------
//   req     | req_valid, req_ready, req  | in        | kind, coord_x, coord_y
//   rsp     | rsp_valid, rsp_ready, rsp  | out       | hit, status, vertex_count
//
// Clear, append, a query on fewer than three vertices and a translate of an
// empty store respond in the cycle after acceptance. Translate and a query
// walk the N held vertices: the vertex memory read port delivers one entry
// per cycle, and a query adds the four-stage area pipeline.
// Reset empties the store; memory contents are not cleared.
// One request is worked at a time; a new request is taken only when the output
// register is empty or its response leaves in the same cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module polygon_fan_hit_test_unit
	import pfht_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  issue_q;
	logic [1:0]        op_q;
	point_t            pt_q;
	logic              hit_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	point_t            mem_q [MAX_VERTICES];
	logic              rvalid_s1;
	logic [ADDR_W-1:0] ridx_s1;
	point_t            rdata_s1;
	point_t            v0_q;
	point_t            prev_q;

	logic              accept;
	logic              rsp_load;
	logic              rd_en;
	logic              done;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	point_t            wdata;
	point_t            req_pt;
	point_t            sat_pt;
	tri_req_t          tri_req;
	tri_stat_t         tri_stat;

	function automatic logic signed [COORD_W-1:0] sat_add(logic signed [COORD_W-1:0] a,
	                                                      logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] s;
		s = (COORD_W + 1)'(a) + (COORD_W + 1)'(b);
		if (s[COORD_W] != s[COORD_W-1])
			return s[COORD_W] ? {1'b1, {(COORD_W - 1){1'b0}}} : {1'b0, {(COORD_W - 1){1'b1}}};
		return s[COORD_W-1:0];
	endfunction

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_pt.x = req.coord_x;
	assign req_pt.y = req.coord_y;
	assign sat_pt.x = sat_add(rdata_s1.x, pt_q.x);
	assign sat_pt.y = sat_add(rdata_s1.y, pt_q.y);

	assign rd_en = (state_q == ST_RUN) && (issue_q < count_q);
	assign done  = (state_q == ST_RUN) && (issue_q == count_q) && !rvalid_s1 && !tri_stat.busy;

	// requests that answer right away, or the end of a memory walk
	assign rsp_load = done || (accept && ((req.kind inside {KIND_CLEAR, KIND_APPEND})
		|| ((req.kind == KIND_QUERY) && (count_q < CNT_W'(3)))
		|| ((req.kind == KIND_TRANSLATE) && (count_q == '0))));

	always_comb begin
		if (state_q == ST_IDLE) begin
			we    = accept && (req.kind == KIND_APPEND) && (count_q < CNT_W'(MAX_VERTICES));
			waddr = count_q[ADDR_W-1:0];
			wdata = req_pt;
		end else begin
			we    = rvalid_s1 && (op_q == KIND_TRANSLATE);
			waddr = ridx_s1;
			wdata = sat_pt;
		end
	end

	// vertex memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (rd_en)
			rdata_s1 <= mem_q[issue_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rvalid_s1 <= 1'b0;
		else
			rvalid_s1 <= rd_en;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			ridx_s1 <= issue_q[ADDR_W-1:0];
		if (rvalid_s1) begin
			prev_q <= rdata_s1;
			if (ridx_s1 == '0)
				v0_q <= rdata_s1;
		end
	end

	assign tri_req.valid = rvalid_s1 && (op_q == KIND_QUERY) && (ridx_s1[ADDR_W-1:1] != '0);
	assign tri_req.v0    = v0_q;
	assign tri_req.va    = prev_q;
	assign tri_req.vb    = rdata_s1;
	assign tri_req.vp    = pt_q;

	pfht_tri_area u_tri_area (
		.clk      (clk),
		.arst_n   (arst_n),
		.tri_req  (tri_req),
		.tri_stat (tri_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			op_q        <= KIND_CLEAR;
			pt_q        <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= req.kind;
						pt_q    <= req_pt;
						issue_q <= '0;
						hit_q   <= 1'b0;
						unique case (req.kind)
							KIND_CLEAR: begin
								count_q <= '0;
								rsp_q   <= '0;
							end
							KIND_APPEND: begin
								rsp_q.hit <= 1'b0;
								if (count_q < CNT_W'(MAX_VERTICES)) begin
									count_q            <= count_q + 1'b1;
									rsp_q.status       <= 1'b0;
									rsp_q.vertex_count <= count_q + 1'b1;
								end else begin
									rsp_q.status       <= 1'b1;
									rsp_q.vertex_count <= count_q;
								end
							end
							KIND_QUERY: begin
								if (count_q < CNT_W'(3)) begin
									rsp_q.hit          <= 1'b0;
									rsp_q.status       <= 1'b0;
									rsp_q.vertex_count <= count_q;
								end else begin
									state_q <= ST_RUN;
								end
							end
							KIND_TRANSLATE: begin
								if (count_q == '0)
									rsp_q <= '0;
								else
									state_q <= ST_RUN;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (rd_en)
						issue_q <= issue_q + 1'b1;
					if (tri_stat.hit)
						hit_q <= 1'b1;
					if (done) begin
						rsp_q.hit          <= hit_q;
						rsp_q.status       <= 1'b0;
						rsp_q.vertex_count <= count_q;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/pfht_tri_area.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pfht_tri_area
// Pipelined area test of one fan triangle per cycle: differences, cross
// products, absolute values, then sum and compare.
// -----------------------------------------------------------------------------
`default_nettype none

module pfht_tri_area
	import pfht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tri_req_t  tri_req,
	output tri_stat_t      tri_stat
);

	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * DW;
	localparam int CW = PW + 1;

	function automatic logic signed [DW-1:0] sub_c(logic signed [COORD_W-1:0] a,
	                                                 logic signed [COORD_W-1:0] b);
		return DW'(a) - DW'(b);
	endfunction

	function automatic logic [AREA_W-1:0] abs_cross(logic signed [PW-1:0] p0,
	                                                logic signed [PW-1:0] p1);
		logic signed [CW-1:0] c;
		logic [CW-1:0]        m;
		c = CW'(p0) - CW'(p1);
		m = c[CW-1] ? CW'(-c) : CW'(c);
		return AREA_W'(m);
	endfunction

	// s2: edge vectors
	logic                 v_s2;
	logic signed [DW-1:0] av_x_s2, av_y_s2, bv_x_s2, bv_y_s2, pv_x_s2, pv_y_s2;
	logic signed [DW-1:0] ap_x_s2, ap_y_s2, bp_x_s2, bp_y_s2;
	// s3: products
	logic                 v_s3;
	logic signed [PW-1:0] pr_s3 [8];
	// s4: absolute doubled areas
	logic                 v_s4;
	logic [AREA_W-1:0]    whole_s4, p1_s4, p2_s4, p3_s4;
	// s5: compare result
	logic                 v_s5;
	logic                 eq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= tri_req.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		av_x_s2 <= sub_c(tri_req.va.x, tri_req.v0.x);
		av_y_s2 <= sub_c(tri_req.va.y, tri_req.v0.y);
		bv_x_s2 <= sub_c(tri_req.vb.x, tri_req.v0.x);
		bv_y_s2 <= sub_c(tri_req.vb.y, tri_req.v0.y);
		pv_x_s2 <= sub_c(tri_req.vp.x, tri_req.v0.x);
		pv_y_s2 <= sub_c(tri_req.vp.y, tri_req.v0.y);
		ap_x_s2 <= sub_c(tri_req.va.x, tri_req.vp.x);
		ap_y_s2 <= sub_c(tri_req.va.y, tri_req.vp.y);
		bp_x_s2 <= sub_c(tri_req.vb.x, tri_req.vp.x);
		bp_y_s2 <= sub_c(tri_req.vb.y, tri_req.vp.y);

		pr_s3[0] <= PW'(av_x_s2) * PW'(bv_y_s2);
		pr_s3[1] <= PW'(av_y_s2) * PW'(bv_x_s2);
		pr_s3[2] <= PW'(ap_x_s2) * PW'(bp_y_s2);
		pr_s3[3] <= PW'(ap_y_s2) * PW'(bp_x_s2);
		pr_s3[4] <= PW'(pv_x_s2) * PW'(bv_y_s2);
		pr_s3[5] <= PW'(pv_y_s2) * PW'(bv_x_s2);
		pr_s3[6] <= PW'(av_x_s2) * PW'(pv_y_s2);
		pr_s3[7] <= PW'(av_y_s2) * PW'(pv_x_s2);

		whole_s4 <= abs_cross(pr_s3[0], pr_s3[1]);
		p1_s4    <= abs_cross(pr_s3[2], pr_s3[3]);
		p2_s4    <= abs_cross(pr_s3[4], pr_s3[5]);
		p3_s4    <= abs_cross(pr_s3[6], pr_s3[7]);

		eq_s5 <= (whole_s4 == (p1_s4 + p2_s4 + p3_s4));
	end

	assign tri_stat.busy = v_s2 | v_s3 | v_s4 | v_s5;
	assign tri_stat.hit  = v_s5 & eq_s5;

endmodule

`default_nettype wire
